FILE: sv/joystick_peak_meter_with_tone_sweep_core_defines.svh
// Assertion macros shared by the joystick peak meter RTL.
// Bodies are empty when SYNTHESIS is defined; no other dependencies.
`ifndef JOYSTICK_PEAK_METER_WITH_TONE_SWEEP_CORE_DEFINES_SVH
`define JOYSTICK_PEAK_METER_WITH_TONE_SWEEP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define JPM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define JPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define JPM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define JPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: sv/jpm_pkg.sv
// Shared types, constants and helper functions for the joystick peak meter.
// No dependencies; imported by every module of the block.
package jpm_pkg;

	localparam int SWEEP_STEPS_DEF = 10;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_METER  = 2'd1;
	localparam logic [1:0] OP_POWER  = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic CFG_DEADZONE = 1'b0;
	localparam logic CFG_DEBOUNCE = 1'b1;

	localparam logic [11:0] CENTER        = 12'd2048;
	localparam logic [11:0] DEADZONE_RST  = 12'd40;
	localparam logic [15:0] DEBOUNCE_RST  = 16'd400;
	localparam logic [22:0] PERIOD_MAX    = 23'h7FFFFF;

	// tone base = 200*2048 + peak*1800, peak <= 2048 -> below 2^22
	localparam int          BASE_W     = 22;
	localparam logic [21:0] BASE0      = 22'd409600;
	localparam logic [10:0] BASE_SLOPE = 11'd1800;

	localparam logic [63:0] CLK_X_CENTER = 64'd125000000 * 64'd2048;

	localparam int STEP_W_DEF = $clog2(SWEEP_STEPS_DEF + 1);
	localparam int NUM_W_DEF  = $clog2(CLK_X_CENTER * 64'(SWEEP_STEPS_DEF) + 64'd1);
	localparam int DEN_W_DEF  = BASE_W + STEP_W_DEF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_MUL,
		ST_DWAIT,
		ST_EMIT,
		ST_TOFF
	} state_t;

	typedef struct packed {
		logic [2:0]  level;
		logic [11:0] duty;
		logic        lamp_write;
		logic [22:0] period;
		logic        tone_on;
		logic        blank;
		logic        last;
	} res_t;

	// floor(p * 4095 / 2048)
	function automatic logic [11:0] duty_of(input logic [11:0] p);
		logic [23:0] t;
		t = {p, 12'd0} - {12'd0, p};
		return t[22:11];
	endfunction

	function automatic logic [2:0] level_of(input logic [11:0] p);
		logic [15:0] t;
		t = 16'(p) * 16'd10;
		if (t <= 16'd2048)       return 3'd0;
		else if (t <= 16'd4096)  return 3'd1;
		else if (t <= 16'd8192)  return 3'd2;
		else if (t <= 16'd12288) return 3'd3;
		else if (t <= 16'd16384) return 3'd4;
		else                     return 3'd5;
	endfunction

endpackage

FILE: sv/jpm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, shifted in at the LSB.
// Depends on jpm_pkg for default widths.
module jpm_div import jpm_pkg::*; #(
	parameter int NUM_W = NUM_W_DEF,
	parameter int DEN_W = DEN_W_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: sv/jpm_out.sv
// Output holding register for result transactions, valid/stall handshake.
// Depends on jpm_pkg for the result struct.
module jpm_out import jpm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t d,
	input  logic stall,
	output logic free,
	output logic valid,
	output res_t q
);

	logic valid_q;
	res_t res_q;

	assign free = !valid_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= d;
		end
	end

	assign valid = valid_q;
	assign q     = res_q;

endmodule

FILE: sv/joystick_peak_meter_with_tone_sweep_core.sv
// Top level of the joystick peak meter with tone sweep: control FSM and state.
// Depends on jpm_pkg, jpm_div, jpm_out and the assertion macro header.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in      | in        | in_valid/in_stall  | op, sample, now_ms
//   out     | out       | out_valid/out_stall| pattern_level .. last (7 fields)
//   cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Presses and plain samples give one result.
// A sample that triggers feedback at a nonzero level runs SWEEP_STEPS tone
// steps, each set by the one-bit-per-cycle divider, plus a base step and a
// tone-off result. No clearing pass after reset.
// in_stall holds while a sweep runs or the output register is full and stalled.
`include "joystick_peak_meter_with_tone_sweep_core_defines.svh"
module joystick_peak_meter_with_tone_sweep_core import jpm_pkg::*; #(
	parameter int SWEEP_STEPS = SWEEP_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [11:0] sample,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  pattern_level,
	output logic [11:0] lamp_duty,
	output logic        lamp_write,
	output logic [22:0] tone_period,
	output logic        tone_on,
	output logic        outputs_blank,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int          STEP_W   = $clog2(SWEEP_STEPS + 1);
	localparam logic [63:0] DIVIDEND = CLK_X_CENTER * 64'(SWEEP_STEPS);
	localparam int          NUM_W    = $clog2(DIVIDEND + 64'd1);
	localparam int          DEN_W    = BASE_W + STEP_W;

	state_t state_q, state_d;

	logic [11:0] deadzone_q;
	logic [15:0] debounce_q;
	logic [11:0] peak_q;
	logic [2:0]  level_q;
	logic        req_q;
	logic        powered_q;
	logic        banner_q;
	logic [31:0] meter_t_q;
	logic [31:0] power_t_q;
	logic [31:0] clear_t_q;
	logic [BASE_W-1:0] base_q;
	logic [STEP_W-1:0] step_q;

	logic        in_fire;
	logic        out_free;
	logic        out_load;
	res_t        load_res;
	res_t        out_res;
	logic        div_start;
	logic        div_done;
	logic [NUM_W-1:0] div_quo;
	logic [DEN_W-1:0] den_c;
	logic [STEP_W-1:0] mult_c;

	logic [31:0] stamp_sel;
	logic        acc;
	logic [12:0] diff_c;
	logic [11:0] delta_c;
	logic [11:0] new_peak;
	logic        sweep_go;
	logic        last_step;
	logic [NUM_W-1:0] quo_m1;
	logic [22:0] period_c;
	res_t        item_res;

	// debounce against the stamp of the pressed button
	always_comb begin
		case (op)
			OP_METER: stamp_sel = meter_t_q;
			OP_POWER: stamp_sel = power_t_q;
			OP_CLEAR: stamp_sel = clear_t_q;
			default:  stamp_sel = 32'd0;
		endcase
	end
	assign acc = (now_ms - stamp_sel) >= {16'd0, debounce_q};

	assign diff_c   = {1'b0, sample} - {1'b0, CENTER};
	assign delta_c  = diff_c[12] ? (CENTER - sample) : diff_c[11:0];
	assign new_peak = ((delta_c >= deadzone_q) && (delta_c > peak_q)) ? delta_c : peak_q;

	assign sweep_go  = (op == OP_SAMPLE) && powered_q && req_q && (level_q != 3'd0);
	assign in_stall  = !((state_q == ST_IDLE) && out_free);
	assign in_fire   = in_valid && !in_stall;
	assign last_step = step_q == STEP_W'(SWEEP_STEPS - 1);
	assign cfg_ready = 1'b1;

	assign mult_c = STEP_W'(SWEEP_STEPS) - step_q;
	assign den_c  = base_q * mult_c;

	// period = quotient - 1, saturated to the 23-bit field
	assign quo_m1 = div_quo - NUM_W'(1);
	always_comb begin
		if (div_quo == '0) begin
			period_c = '0;
		end else if (quo_m1 > NUM_W'(PERIOD_MAX)) begin
			period_c = PERIOD_MAX;
		end else begin
			period_c = quo_m1[22:0];
		end
	end

	// single result of a press or a sample without sweep
	always_comb begin
		item_res            = '0;
		item_res.last       = 1'b1;
		item_res.level      = level_q;
		case (op)
			OP_METER: begin
				if (acc) item_res.level = level_of(peak_q);
			end
			OP_POWER: begin
				item_res.level = level_q;
			end
			OP_CLEAR: begin
				if (acc) begin
					item_res.level      = 3'd0;
					item_res.lamp_write = 1'b1;
				end
			end
			default: begin
				if (!powered_q) begin
					item_res.level      = 3'd0;
					item_res.lamp_write = 1'b1;
					item_res.blank      = 1'b1;
				end else if (req_q) begin
					// level zero feedback: lamp off
					item_res.level      = 3'd0;
					item_res.lamp_write = 1'b1;
				end else if (!banner_q) begin
					item_res.lamp_write = 1'b1;
					item_res.duty       = duty_of(peak_q);
				end
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_fire && sweep_go) state_d = ST_BASE;
			ST_BASE:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_DWAIT;
			ST_DWAIT: if (div_done) state_d = ST_EMIT;
			ST_EMIT:  if (out_free) state_d = last_step ? ST_TOFF : ST_MUL;
			ST_TOFF:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		out_load  = 1'b0;
		load_res  = '0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				out_load = in_fire && !sweep_go;
				load_res = item_res;
			end
			ST_MUL: begin
				div_start = 1'b1;
			end
			ST_EMIT: begin
				out_load            = out_free;
				load_res.level      = level_q;
				load_res.duty       = (step_q == '0) ? duty_of(peak_q) : 12'd0;
				load_res.lamp_write = step_q == '0;
				load_res.period     = period_c;
				load_res.tone_on    = 1'b1;
			end
			ST_TOFF: begin
				out_load       = out_free;
				load_res.level = level_q;
				load_res.last  = 1'b1;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			deadzone_q <= DEADZONE_RST;
			debounce_q <= DEBOUNCE_RST;
			peak_q     <= '0;
			level_q    <= '0;
			req_q      <= 1'b0;
			powered_q  <= 1'b1;
			banner_q   <= 1'b0;
			meter_t_q  <= '0;
			power_t_q  <= '0;
			clear_t_q  <= '0;
			step_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DEADZONE: deadzone_q <= cfg_data[11:0];
					CFG_DEBOUNCE: debounce_q <= cfg_data;
					default:      debounce_q <= debounce_q;
				endcase
			end
			if (in_fire) begin
				case (op)
					OP_METER: begin
						if (acc) begin
							meter_t_q <= now_ms;
							level_q   <= level_of(peak_q);
							req_q     <= 1'b1;
						end
					end
					OP_POWER: begin
						if (acc) begin
							power_t_q <= now_ms;
							powered_q <= !powered_q;
						end
					end
					OP_CLEAR: begin
						if (acc) begin
							clear_t_q <= now_ms;
							level_q   <= '0;
							peak_q    <= '0;
							req_q     <= 1'b0;
						end
					end
					default: begin
						if (!powered_q) begin
							banner_q <= 1'b0;
						end else begin
							banner_q <= 1'b1;
							step_q   <= '0;
							// level zero feedback finishes here; a sweep clears at tone-off
							if (req_q && (level_q == 3'd0)) begin
								peak_q <= '0;
								req_q  <= 1'b0;
							end else begin
								peak_q <= new_peak;
							end
						end
					end
				endcase
			end
			if ((state_q == ST_EMIT) && out_free) begin
				step_q <= step_q + STEP_W'(1);
			end
			if ((state_q == ST_TOFF) && out_free) begin
				peak_q <= '0;
				req_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_BASE) begin
			base_q <= BASE0 + BASE_W'(peak_q * BASE_SLOPE);
		end
	end

	jpm_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIVIDEND[NUM_W-1:0]),
		.divisor  (den_c),
		.done     (div_done),
		.quotient (div_quo)
	);

	jpm_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.d      (load_res),
		.stall  (out_stall),
		.free   (out_free),
		.valid  (out_valid),
		.q      (out_res)
	);

	assign pattern_level = out_res.level;
	assign lamp_duty     = out_res.duty;
	assign lamp_write    = out_res.lamp_write;
	assign tone_period   = out_res.period;
	assign tone_on       = out_res.tone_on;
	assign outputs_blank = out_res.blank;
	assign last          = out_res.last;

	`JPM_ASSERT_IMPL(a_peak_range, clk, arst_n, 1'b1, peak_q <= CENTER, "peak above center range")
	`JPM_ASSERT_NEXT(a_div_to_emit, clk, arst_n, (state_q == ST_DWAIT) && div_done, state_q == ST_EMIT, "divider result not taken")
	`JPM_ASSERT_NEXT(a_last_ends_item, clk, arst_n, out_load && load_res.last, state_q == ST_IDLE, "final result without return to idle")
	`JPM_ASSERT_IMPL(a_level_range, clk, arst_n, 1'b1, level_q <= 3'd5, "meter level above five")

endmodule
